>>> design/cpq_pkg.sv
// Shared types, palette table and distance functions for the palette quantizer.
package cpq_pkg;

   localparam int CHAN_W = 8;
   localparam int DIST_W = 18;
   localparam int IDX_W  = 4;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } rgb_type;

   // Everything that moves from one cell to the next.
   typedef struct packed {
      rgb_type  pixel;
      rgb_type  approx;
      dist_type dir_dist;
      idx_type  dir_idx;
      dist_type apx_dist;
      idx_type  apx_idx;
   } link_type;

   localparam chan_type LEVEL_0   = 8'd0;
   localparam chan_type LEVEL_85  = 8'd85;
   localparam chan_type LEVEL_170 = 8'd170;
   localparam chan_type LEVEL_255 = 8'd255;

   function automatic rgb_type palette_entry(input idx_type k);
      rgb_type c;
      case (k)
         4'd0:    c = '{8'd0,   8'd0,   8'd0};
         4'd1:    c = '{8'd0,   8'd0,   8'd128};
         4'd2:    c = '{8'd0,   8'd128, 8'd0};
         4'd3:    c = '{8'd0,   8'd128, 8'd128};
         4'd4:    c = '{8'd128, 8'd0,   8'd0};
         4'd5:    c = '{8'd128, 8'd0,   8'd128};
         4'd6:    c = '{8'd128, 8'd128, 8'd0};
         4'd7:    c = '{8'd192, 8'd192, 8'd192};
         4'd8:    c = '{8'd128, 8'd128, 8'd128};
         4'd9:    c = '{8'd0,   8'd0,   8'd255};
         4'd10:   c = '{8'd0,   8'd255, 8'd0};
         4'd11:   c = '{8'd0,   8'd255, 8'd255};
         4'd12:   c = '{8'd255, 8'd0,   8'd0};
         4'd13:   c = '{8'd255, 8'd0,   8'd255};
         4'd14:   c = '{8'd255, 8'd255, 8'd0};
         default: c = '{8'd255, 8'd255, 8'd255};
      endcase
      return c;
   endfunction

   function automatic logic [2*CHAN_W-1:0] sq_diff(input chan_type a, input chan_type b);
      chan_type d;
      d = (a > b) ? (a - b) : (b - a);
      return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
   endfunction

   function automatic dist_type dist3(input rgb_type p, input rgb_type q);
      return {2'b00, sq_diff(p.red, q.red)} + {2'b00, sq_diff(p.green, q.green)}
           + {2'b00, sq_diff(p.blue, q.blue)};
   endfunction

endpackage

>>> design/cpq_approx.sv
// Front stage: builds the RGBI approximation and seeds the search link.
module cpq_approx (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  cpq_pkg::rgb_type  in_pixel,
   output logic              out_valid,
   output cpq_pkg::link_type out_link
);

   logic              valid_ff;
   cpq_pkg::link_type link_ff, link_in;
   cpq_pkg::rgb_type  dark, bright;
   cpq_pkg::dist_type d_dark, d_bright;

   function automatic cpq_pkg::chan_type dark_level(input cpq_pkg::chan_type c);
      return (c > cpq_pkg::LEVEL_85) ? cpq_pkg::LEVEL_170 : cpq_pkg::LEVEL_0;
   endfunction

   function automatic cpq_pkg::chan_type bright_level(input cpq_pkg::chan_type c);
      return (c > cpq_pkg::LEVEL_170) ? cpq_pkg::LEVEL_255 : cpq_pkg::LEVEL_85;
   endfunction

   always_comb begin
      dark.red      = dark_level(in_pixel.red);
      dark.green    = dark_level(in_pixel.green);
      dark.blue     = dark_level(in_pixel.blue);
      bright.red    = bright_level(in_pixel.red);
      bright.green  = bright_level(in_pixel.green);
      bright.blue   = bright_level(in_pixel.blue);
      d_dark        = cpq_pkg::dist3(in_pixel, dark);
      d_bright      = cpq_pkg::dist3(in_pixel, bright);
      link_in.pixel = in_pixel;
      // Ties go to the dark candidate.
      link_in.approx = (d_dark <= d_bright) ? dark : bright;
      // All-ones distance exceeds any real distance, so the first cell always wins.
      link_in.dir_dist = '1;
      link_in.dir_idx  = '0;
      link_in.apx_dist = '1;
      link_in.apx_idx  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         link_ff <= link_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_link  = link_ff;

endmodule

>>> design/cpq_cell.sv
// One search cell: holds a palette entry and updates both running minimums.
module cpq_cell #(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  cpq_pkg::link_type in_link,
   output logic              out_valid,
   output cpq_pkg::link_type out_link
);

   localparam cpq_pkg::idx_type ENTRY_IDX = cpq_pkg::idx_type'(INDEX);
   localparam cpq_pkg::rgb_type ENTRY     = cpq_pkg::palette_entry(ENTRY_IDX);

   logic              valid_ff;
   cpq_pkg::link_type link_ff, link_in;
   cpq_pkg::dist_type d_dir, d_apx;

   always_comb begin
      d_dir   = cpq_pkg::dist3(in_link.pixel, ENTRY);
      d_apx   = cpq_pkg::dist3(in_link.approx, ENTRY);
      link_in = in_link;
      // Strict compare keeps the lower index on ties.
      if (d_dir < in_link.dir_dist) begin
         link_in.dir_dist = d_dir;
         link_in.dir_idx  = ENTRY_IDX;
      end
      if (d_apx < in_link.apx_dist) begin
         link_in.apx_dist = d_apx;
         link_in.apx_idx  = ENTRY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         link_ff <= link_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_link  = link_ff;

endmodule

>>> design/console_palette_pixel_quantizer.sv
// Top level: approximation stage followed by a row of palette search cells.
// Throughput: one item per clock; one approximation stage and one cell per palette entry.
// A stall on the result side holds the whole row; input is taken again once it moves.
// Reset (synchronous, active high) clears all valid bits; the link data is not reset.
module console_palette_pixel_quantizer #(
   parameter int PALETTE_SIZE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // pixel_red, pixel_green, pixel_blue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // direct_index, approx_red, approx_green, approx_blue,
                                   // approx_index
);

   logic              valid [PALETTE_SIZE+1];
   cpq_pkg::link_type links [PALETTE_SIZE+1];
   cpq_pkg::rgb_type  pixel;
   logic              advance;

   assign advance     = !valid[PALETTE_SIZE] || rsp_tready;
   assign req_tready  = advance;
   assign pixel.red   = req_tdata[7:0];
   assign pixel.green = req_tdata[15:8];
   assign pixel.blue  = req_tdata[23:16];

   cpq_approx u_approx (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_pixel  (pixel),
      .out_valid (valid[0]),
      .out_link  (links[0])
   );

   for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
      cpq_cell #(.INDEX(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid[k]),
         .in_link   (links[k]),
         .out_valid (valid[k+1]),
         .out_link  (links[k+1])
      );
   end

   assign rsp_tvalid = valid[PALETTE_SIZE];
   assign rsp_tdata  = {links[PALETTE_SIZE].apx_idx,
                        links[PALETTE_SIZE].approx.blue,
                        links[PALETTE_SIZE].approx.green,
                        links[PALETTE_SIZE].approx.red,
                        links[PALETTE_SIZE].dir_idx};

   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while the result row is stalled");

   a_index_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[3:0]) < PALETTE_SIZE) &&
                     (32'(rsp_tdata[31:28]) < PALETTE_SIZE))
      else $error("palette index beyond the searched entries");

   a_approx_levels : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:4] == 8'd0 || rsp_tdata[11:4] == 8'd85 ||
                      rsp_tdata[11:4] == 8'd170 || rsp_tdata[11:4] == 8'd255) &&
                     (rsp_tdata[19:12] == 8'd0 || rsp_tdata[19:12] == 8'd85 ||
                      rsp_tdata[19:12] == 8'd170 || rsp_tdata[19:12] == 8'd255) &&
                     (rsp_tdata[27:20] == 8'd0 || rsp_tdata[27:20] == 8'd85 ||
                      rsp_tdata[27:20] == 8'd170 || rsp_tdata[27:20] == 8'd255))
      else $error("approximation channel is not an RGBI level");

endmodule
